@@ sv/iec_pkg.sv @@
// Shared types, codes and widths for the input event coalescer.
package iec_pkg;

  localparam int unsigned KindW    = 2;
  localparam int unsigned PadNumW  = 4;
  localparam int unsigned PadMaskW = 16;
  localparam int unsigned ButtonsW = 16;
  localparam int unsigned TrigW    = 8;
  localparam int unsigned ValueW   = 16;

  // Packed payload widths: the fields add up to 116 bits, padded to whole bytes.
  localparam int unsigned PayloadW  = PadNumW + PadMaskW + ButtonsW + 2 * TrigW + 4 * ValueW;
  localparam int unsigned TdataW    = ((PayloadW + 7) / 8) * 8;
  localparam int unsigned PadW      = TdataW - PayloadW;
  localparam int unsigned InTuserW  = 1 + KindW;
  localparam int unsigned OutTuserW = KindW;

  // Operation codes.
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Event kind codes.
  localparam logic [KindW-1:0] KIND_REL   = 2'd0;
  localparam logic [KindW-1:0] KIND_ABS   = 2'd1;
  localparam logic [KindW-1:0] KIND_PAD   = 2'd2;
  localparam logic [KindW-1:0] KIND_OTHER = 2'd3;

  // One event as it is held and emitted.
  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [PadNumW-1:0]      pad_number;
    logic [PadMaskW-1:0]     pad_mask;
    logic [ButtonsW-1:0]     buttons;
    logic [TrigW-1:0]        trigger_left;
    logic [TrigW-1:0]        trigger_right;
    logic signed [ValueW-1:0] value_a;
    logic signed [ValueW-1:0] value_b;
    logic signed [ValueW-1:0] value_c;
    logic signed [ValueW-1:0] value_d;
  } iec_event_t;

  // One input word: an operation and the event that comes with it.
  typedef struct packed {
    logic       op;
    iec_event_t evt;
  } iec_item_t;

  // Handshake between the merge core and the output register.
  typedef struct packed {
    logic step;   // the core consumes its input word in this cycle
    logic emit;   // that step releases the held event as a result
  } iec_ctl_t;

endpackage

@@ sv/iec_core.sv @@
// Held-event store and the merge decision for one input word per cycle while step_i is high.
module iec_core import iec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  iec_item_t  item_i,
  output iec_ctl_t   ctl_o,
  output iec_event_t emit_evt_o
);

  logic       held_valid_q, held_valid_d;
  iec_event_t held_q, held_d;
  iec_event_t new_evt;

  logic [ValueW:0] sum_x, sum_y;
  logic            sum_ovf;
  logic            same_kind, pad_match, merge;

  // The event as it is stored fresh: fields without meaning for its kind are zero.
  always_comb begin
    new_evt      = '0;
    new_evt.kind = item_i.evt.kind;
    case (item_i.evt.kind)
      KIND_REL: begin
        new_evt.value_a = item_i.evt.value_a;
        new_evt.value_b = item_i.evt.value_b;
      end
      KIND_ABS: begin
        new_evt.value_a = item_i.evt.value_a;
        new_evt.value_b = item_i.evt.value_b;
        new_evt.value_c = item_i.evt.value_c;
        new_evt.value_d = item_i.evt.value_d;
      end
      KIND_PAD: begin
        new_evt = item_i.evt;
      end
      default: begin
        new_evt.kind = item_i.evt.kind;
      end
    endcase
  end

  assign sum_x = {held_q.value_a[ValueW-1], held_q.value_a}
               + {item_i.evt.value_a[ValueW-1], item_i.evt.value_a};
  assign sum_y = {held_q.value_b[ValueW-1], held_q.value_b}
               + {item_i.evt.value_b[ValueW-1], item_i.evt.value_b};
  assign sum_ovf = (sum_x[ValueW] != sum_x[ValueW-1]) || (sum_y[ValueW] != sum_y[ValueW-1]);

  assign same_kind = held_valid_q && (held_q.kind == item_i.evt.kind);
  assign pad_match = (held_q.pad_number == item_i.evt.pad_number)
                  && (held_q.pad_mask == item_i.evt.pad_mask)
                  && (held_q.buttons == item_i.evt.buttons);

  always_comb begin
    merge = 1'b0;
    case (item_i.evt.kind)
      KIND_REL: merge = same_kind && !sum_ovf;
      KIND_ABS: merge = same_kind;
      KIND_PAD: merge = same_kind && pad_match;
      default:  merge = 1'b0;
    endcase
  end

  // A matching gamepad state differs only in triggers and sticks, so storing the
  // fresh event is the same as overwriting those fields.
  always_comb begin
    held_valid_d = held_valid_q;
    held_d       = held_q;
    ctl_o.step   = step_i;
    ctl_o.emit   = 1'b0;
    if (step_i) begin
      if (item_i.op == OP_FLUSH) begin
        ctl_o.emit   = held_valid_q;
        held_valid_d = 1'b0;
      end else if (merge && (item_i.evt.kind == KIND_REL)) begin
        held_d.value_a = sum_x[ValueW-1:0];
        held_d.value_b = sum_y[ValueW-1:0];
      end else begin
        ctl_o.emit   = held_valid_q && !merge;
        held_valid_d = 1'b1;
        held_d       = new_evt;
      end
    end
  end

  assign emit_evt_o = held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_q       <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
    end
  end

`ifndef SYNTHESIS
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.op == OP_FLUSH) |=> !held_valid_q)
    else $error("flush left an event held");

  a_event_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.op == OP_EVENT) |=> held_valid_q)
    else $error("new event was not held");

  a_emit_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit |-> held_valid_q && step_i)
    else $error("emitted with nothing held");

  a_rel_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q && (held_q.kind == KIND_REL) |->
      (held_q.pad_mask == '0) && (held_q.buttons == '0) &&
      (held_q.value_c == '0) && (held_q.value_d == '0))
    else $error("held motion carries stray fields");

  a_other_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q && (held_q.kind == KIND_OTHER) |->
      (held_q.value_a == '0) && (held_q.value_b == '0) && (held_q.pad_number == '0))
    else $error("held other event carries stray fields");
`endif

endmodule

@@ sv/iec_out_reg.sv @@
// Result register between the merge core and the output stream.
module iec_out_reg import iec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  iec_ctl_t   ctl_i,
  input  iec_event_t evt_i,
  output logic       ready_o,
  output logic       valid_o,
  input  logic       take_i,
  output iec_event_t evt_o
);

  logic       valid_q, valid_d;
  iec_event_t evt_q, evt_d;
  logic       load;

  assign ready_o = !valid_q || take_i;
  assign load    = ctl_i.step && ctl_i.emit;

  always_comb begin
    valid_d = valid_q;
    evt_d   = evt_q;
    if (load) begin
      valid_d = 1'b1;
      evt_d   = evt_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign valid_o = valid_q;
  assign evt_o   = evt_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step |-> ready_o)
    else $error("core stepped while the result register was blocked");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q && (evt_q == $past(evt_i)))
    else $error("loaded result not presented");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> valid_q)
    else $error("unread result dropped");
`endif

endmodule

@@ sv/input_event_coalescer.sv @@
// Top level of the input event coalescer: input register, merge core, result register.
//
//  Channel   Dir  tdata (low bit up)                              tuser
//  s_axis    in   pad_number, pad_mask, buttons, trigger_left,    op, kind
//                 trigger_right, value_a..value_d, 4 zero bits
//  m_axis    out  out_pad_number .. out_value_d, 4 zero bits      out_kind
//
// Every word passes the input register, then the merge logic into the held event,
// which a later word or a flush releases into the result register. One word is
// accepted per cycle while the result side keeps taking; the limit is the
// single held event, which is read and rewritten in the same cycle.
// Reset clears the held event and the valid flags of the input and result registers.
// A stalled result stops the core, and the input register then fills and
// drops s_axis_tready; nothing is lost or repeated.
module input_event_coalescer import iec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TdataW-1:0]    s_axis_tdata,  // pad_number, pad_mask, buttons, trigger_left,
                                              // trigger_right, value_a, b, c, d, pad
  input  logic [InTuserW-1:0]  s_axis_tuser,  // op, kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataW-1:0]    m_axis_tdata,  // out_pad_number, out_pad_mask, out_buttons,
                                              // out_trigger_left, out_trigger_right,
                                              // out_value_a, b, c, d, pad
  output logic [OutTuserW-1:0] m_axis_tuser   // out_kind
);

  iec_item_t  in_word;
  iec_item_t  in_q, in_d;
  logic       in_valid_q, in_valid_d;
  logic       out_ready;
  logic       step;
  iec_ctl_t   ctl;
  iec_event_t held_evt;
  iec_event_t out_evt;

  // Unpack the stream word into the item record.
  always_comb begin
    in_word                   = '0;
    in_word.op                = s_axis_tuser[0];
    in_word.evt.kind          = s_axis_tuser[InTuserW-1:1];
    {in_word.evt.value_d, in_word.evt.value_c, in_word.evt.value_b, in_word.evt.value_a,
     in_word.evt.trigger_right, in_word.evt.trigger_left, in_word.evt.buttons,
     in_word.evt.pad_mask, in_word.evt.pad_number} = s_axis_tdata[PayloadW-1:0];
  end

  // The core works on the registered word whenever the result register can take
  // whatever this step may release.
  assign step          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      in_d       = in_word;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  iec_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .ctl_o      (ctl),
    .emit_evt_o (held_evt)
  );

  iec_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .evt_i   (held_evt),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .evt_o   (out_evt)
  );

  // Pack the result word, padding the top with zeros.
  assign m_axis_tuser = out_evt.kind;
  assign m_axis_tdata = {{PadW{1'b0}},
                         out_evt.value_d, out_evt.value_c, out_evt.value_b, out_evt.value_a,
                         out_evt.trigger_right, out_evt.trigger_left, out_evt.buttons,
                         out_evt.pad_mask, out_evt.pad_number};

endmodule

@@ tb/sv/iec_merge_checker.sv @@
// Checker for the input event coalescer: predicts emitted events and compares them.
module iec_merge_checker import iec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [TdataW-1:0]    s_tdata_i,
  input  logic [InTuserW-1:0]  s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [TdataW-1:0]    m_tdata_i,
  input  logic [OutTuserW-1:0] m_tuser_i,
  output int                   fail_cnt_o,
  output int                   exp_cnt_o
);

  iec_event_t emitted_q[$];
  iec_event_t pending_evt;
  logic       pending_valid;
  iec_event_t in_evt;
  iec_event_t want;
  iec_event_t got;
  logic       merged;
  int         sum_x;
  int         sum_y;
  int         fail_cnt;
  int         exp_cnt;

  assign fail_cnt_o = fail_cnt;
  assign exp_cnt_o  = exp_cnt;

  function automatic iec_event_t word_to_event(logic [TdataW-1:0] w, logic [KindW-1:0] kind);
    iec_event_t e;
    e.kind          = kind;
    e.pad_number    = w[3:0];
    e.pad_mask      = w[19:4];
    e.buttons       = w[35:20];
    e.trigger_left  = w[43:36];
    e.trigger_right = w[51:44];
    e.value_a       = w[67:52];
    e.value_b       = w[83:68];
    e.value_c       = w[99:84];
    e.value_d       = w[115:100];
    return e;
  endfunction

  // The form in which a fresh event is held: fields that mean nothing for its kind are zero.
  function automatic iec_event_t held_form(iec_event_t e);
    iec_event_t h;
    h      = '0;
    h.kind = e.kind;
    case (e.kind)
      KIND_REL: begin
        h.value_a = e.value_a;
        h.value_b = e.value_b;
      end
      KIND_ABS: begin
        h.value_a = e.value_a;
        h.value_b = e.value_b;
        h.value_c = e.value_c;
        h.value_d = e.value_d;
      end
      KIND_PAD: begin
        h = e;
      end
      default: ;
    endcase
    return h;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitted_q.delete();
      pending_evt   = '0;
      pending_valid = 1'b0;
      fail_cnt      = 0;
      exp_cnt       = 0;
    end else begin
      // Accepted input word: update the predicted held event.
      if (s_tvalid_i && s_tready_i) begin
        in_evt = word_to_event(s_tdata_i, s_tuser_i[2:1]);
        if (s_tuser_i[0] == OP_FLUSH) begin
          if (pending_valid) emitted_q.push_back(pending_evt);
          pending_valid = 1'b0;
        end else begin
          merged = 1'b0;
          if (pending_valid && pending_evt.kind == in_evt.kind) begin
            case (in_evt.kind)
              KIND_REL: begin
                sum_x = int'($signed(pending_evt.value_a)) + int'($signed(in_evt.value_a));
                sum_y = int'($signed(pending_evt.value_b)) + int'($signed(in_evt.value_b));
                if (sum_x >= -32768 && sum_x <= 32767 && sum_y >= -32768 && sum_y <= 32767) begin
                  pending_evt.value_a = sum_x[15:0];
                  pending_evt.value_b = sum_y[15:0];
                  merged = 1'b1;
                end
              end
              KIND_ABS: begin
                pending_evt = held_form(in_evt);
                merged      = 1'b1;
              end
              KIND_PAD: begin
                if (pending_evt.pad_number == in_evt.pad_number &&
                    pending_evt.pad_mask == in_evt.pad_mask &&
                    pending_evt.buttons == in_evt.buttons) begin
                  pending_evt.trigger_left  = in_evt.trigger_left;
                  pending_evt.trigger_right = in_evt.trigger_right;
                  pending_evt.value_a       = in_evt.value_a;
                  pending_evt.value_b       = in_evt.value_b;
                  pending_evt.value_c       = in_evt.value_c;
                  pending_evt.value_d       = in_evt.value_d;
                  merged = 1'b1;
                end
              end
              default: ;
            endcase
          end
          if (!merged) begin
            if (pending_valid) emitted_q.push_back(pending_evt);
            pending_evt   = held_form(in_evt);
            pending_valid = 1'b1;
          end
        end
      end

      // Accepted result word: compare with the oldest prediction.
      if (m_tvalid_i && m_tready_i) begin
        got = word_to_event(m_tdata_i, m_tuser_i);
        if (emitted_q.size() == 0) begin
          $error("unexpected result word: kind %0h", got.kind);
          fail_cnt++;
        end else begin
          want = emitted_q.pop_front();
          check_field("out_kind", 16'(want.kind), 16'(got.kind));
          check_field("out_pad_number", 16'(want.pad_number), 16'(got.pad_number));
          check_field("out_pad_mask", want.pad_mask, got.pad_mask);
          check_field("out_buttons", want.buttons, got.buttons);
          check_field("out_trigger_left", 16'(want.trigger_left), 16'(got.trigger_left));
          check_field("out_trigger_right", 16'(want.trigger_right), 16'(got.trigger_right));
          check_field("out_value_a", want.value_a, got.value_a);
          check_field("out_value_b", want.value_b, got.value_b);
          check_field("out_value_c", want.value_c, got.value_c);
          check_field("out_value_d", want.value_d, got.value_d);
        end
      end
      exp_cnt = emitted_q.size();
    end
  end

endmodule

@@ tb/sv/input_event_coalescer_tb.sv @@
// Testbench top for the input event coalescer: stimulus, back-pressure and the verdict.
module input_event_coalescer_tb;
  import iec_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TdataW-1:0]    s_axis_tdata;
  logic [InTuserW-1:0]  s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TdataW-1:0]    m_axis_tdata;
  logic [OutTuserW-1:0] m_axis_tuser;
  int                   fail_cnt;
  int                   exp_cnt;

  // While calm is set neither side idles, so long back-to-back runs occur as well.
  bit                   calm;

  // Recent history of the random stream, so that runs of one kind and repeated
  // gamepad identities come up often enough for merging to happen.
  logic [KindW-1:0]     run_kind;
  logic [PadNumW-1:0]   run_pad_number;
  logic [PadMaskW-1:0]  run_pad_mask;
  logic [ButtonsW-1:0]  run_buttons;

  input_event_coalescer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  iec_merge_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .fail_cnt_o (fail_cnt),
    .exp_cnt_o  (exp_cnt)
  );

  always #4 clk_i = ~clk_i;

  // The result side stalls with a chance of about seven percent, except while calm.
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
  end

  function automatic iec_item_t make_item(logic op, logic [KindW-1:0] kind,
                                          logic [3:0] pad_number, logic [15:0] pad_mask,
                                          logic [15:0] buttons, logic [7:0] trig_l,
                                          logic [7:0] trig_r, logic [15:0] va,
                                          logic [15:0] vb, logic [15:0] vc,
                                          logic [15:0] vd);
    iec_item_t it;
    it.op                = op;
    it.evt.kind          = kind;
    it.evt.pad_number    = pad_number;
    it.evt.pad_mask      = pad_mask;
    it.evt.buttons       = buttons;
    it.evt.trigger_left  = trig_l;
    it.evt.trigger_right = trig_r;
    it.evt.value_a       = va;
    it.evt.value_b       = vb;
    it.evt.value_c       = vc;
    it.evt.value_d       = vd;
    return it;
  endfunction

  // Presents one word from a falling edge and holds it until it has been taken.
  // It returns at the falling edge after acceptance, with tvalid still high, so
  // that a following word goes out back to back without a gap.
  task automatic send_word(iec_item_t it);
    while (!calm && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PadW{1'b0}}, it.evt.value_d, it.evt.value_c, it.evt.value_b,
                      it.evt.value_a, it.evt.trigger_right, it.evt.trigger_left,
                      it.evt.buttons, it.evt.pad_mask, it.evt.pad_number};
    s_axis_tuser  <= {it.evt.kind, it.op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One random word. Every field starts fully random; events then mostly keep the
  // kind of the run so far, relative motion mostly uses small deltas so that sums
  // grow slowly towards the edges, and gamepad states mostly reuse the identity
  // of the previous one so that they merge.
  task automatic send_random();
    logic [127:0] raw;
    iec_item_t    it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(iec_item_t)-1:0];
    if ($urandom_range(0, 99) < 8) begin
      it.op = OP_FLUSH;
    end else begin
      it.op = OP_EVENT;
      if ($urandom_range(0, 99) >= 70) run_kind = 2'($urandom_range(0, 3));
      it.evt.kind = run_kind;
      case (run_kind)
        KIND_REL: begin
          if ($urandom_range(0, 99) < 80) begin
            it.evt.value_a = 16'($urandom_range(0, 4000)) - 16'd2000;
            it.evt.value_b = 16'($urandom_range(0, 4000)) - 16'd2000;
          end
        end
        KIND_PAD: begin
          if ($urandom_range(0, 99) < 70) begin
            it.evt.pad_number = run_pad_number;
            it.evt.pad_mask   = run_pad_mask;
            it.evt.buttons    = run_buttons;
          end
          run_pad_number = it.evt.pad_number;
          run_pad_mask   = it.evt.pad_mask;
          run_buttons    = it.evt.buttons;
        end
        default: ;
      endcase
    end
    send_word(it);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    calm           = 1'b0;
    run_kind       = KIND_REL;
    run_pad_number = '0;
    run_pad_mask   = '0;
    run_buttons    = '0;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // A flush with nothing held must produce nothing.
    send_word(make_item(OP_FLUSH, KIND_OTHER, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // Relative motion with every meaningless field set; they must come out as zero.
    send_word(make_item(OP_EVENT, KIND_REL, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        16'd100, -16'sd100, 16'h7FFF, 16'h8000));
    // The x sum lands exactly on the positive limit and still merges.
    send_word(make_item(OP_EVENT, KIND_REL, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'd32667, -16'sd5, 16'h0, 16'h0));
    // One more step in x leaves the range: the sum is emitted, the new motion held.
    send_word(make_item(OP_EVENT, KIND_REL, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'd1, 16'd0, 16'h0, 16'h0));
    // Zero motion merges like any other.
    send_word(make_item(OP_EVENT, KIND_REL, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'd0, 16'd0, 16'h0, 16'h0));
    // Most negative deltas: y lands exactly on the negative limit.
    send_word(make_item(OP_EVENT, KIND_REL, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'h8000, 16'h8000, 16'h0, 16'h0));
    // y now falls below the range.
    send_word(make_item(OP_EVENT, KIND_REL, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'd0, -16'sd1, 16'h0, 16'h0));
    // Absolute positions replace one another; pad fields must be dropped.
    send_word(make_item(OP_EVENT, KIND_ABS, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000));
    send_word(make_item(OP_EVENT, KIND_ABS, 4'h5, 16'h1234, 16'h5678, 8'h9A, 8'hBC,
                        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));
    // Gamepad states: a merge on matching identity, a change of each part, then another merge.
    send_word(make_item(OP_EVENT, KIND_PAD, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    send_word(make_item(OP_EVENT, KIND_PAD, 4'hF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00,
                        16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_word(make_item(OP_EVENT, KIND_PAD, 4'hE, 16'hFFFF, 16'hFFFF, 8'h11, 8'h22,
                        16'h0001, 16'h0002, 16'h0003, 16'h0004));
    send_word(make_item(OP_EVENT, KIND_PAD, 4'hE, 16'h0000, 16'hFFFF, 8'h33, 8'h44,
                        16'h0005, 16'h0006, 16'h0007, 16'h0008));
    send_word(make_item(OP_EVENT, KIND_PAD, 4'hE, 16'h0000, 16'h0001, 8'h55, 8'h66,
                        16'h0009, 16'h000A, 16'h000B, 16'h000C));
    send_word(make_item(OP_EVENT, KIND_PAD, 4'hE, 16'h0000, 16'h0001, 8'h80, 8'h01,
                        16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    // Other events never merge and carry nothing but their kind.
    send_word(make_item(OP_EVENT, KIND_OTHER, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_item(OP_EVENT, KIND_OTHER, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_item(OP_FLUSH, KIND_REL, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'h0, 16'h0, 16'h0, 16'h0));
    send_word(make_item(OP_FLUSH, KIND_PAD, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'h0, 16'h0, 16'h0, 16'h0));
    // Changes of kind each emit the previous event.
    send_word(make_item(OP_EVENT, KIND_REL, 4'h3, 16'h0F0F, 16'hF0F0, 8'h5A, 8'hA5,
                        16'h0123, 16'hFEDC, 16'h4567, 16'hBA98));
    send_word(make_item(OP_EVENT, KIND_OTHER, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'h0, 16'h0, 16'h0, 16'h0));
    send_word(make_item(OP_EVENT, KIND_ABS, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'h0, 16'h0, 16'h0, 16'h0));
    send_word(make_item(OP_FLUSH, KIND_ABS, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_item(OP_EVENT, KIND_PAD, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'h0, 16'h0, 16'h0, 16'h0));
    send_word(make_item(OP_FLUSH, KIND_OTHER, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'h0, 16'h0, 16'h0, 16'h0));

    // Random part, with a calm stretch in the middle where neither side idles.
    for (int n = 0; n < 950; n++) begin
      calm = (n >= 400 && n < 600);
      send_random();
    end
    calm = 1'b0;

    // A last flush releases whatever is still held.
    send_word(make_item(OP_FLUSH, KIND_REL, 4'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                        16'h0, 16'h0, 16'h0, 16'h0));
    s_axis_tvalid <= 1'b0;

    // Wait for every predicted word, then go on waiting to catch strays.
    while (exp_cnt != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS input_event_coalescer");
    end else begin
      $display("FAIL input_event_coalescer");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every stall.
  initial begin
    #800000;
    $display("FAIL input_event_coalescer");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/iec_pkg.sv
sv/iec_core.sv
sv/iec_out_reg.sv
sv/input_event_coalescer.sv
tb/sv/iec_merge_checker.sv
tb/sv/input_event_coalescer_tb.sv
